/* rtl/core/apq_pkg.sv */
// shared types and constants of the arp pending retry queue
package apq_pkg;

  localparam int OP_W      = 2;
  localparam int ACT_W     = 3;
  localparam int HANDLE_W  = 8;
  localparam int IP_W      = 32;
  localparam int MASK_W    = 32;
  localparam int MAC_W     = 48;
  localparam int ELAPSED_W = 16;
  localparam int TRIES_W   = 4;
  localparam int TIME_W    = 16;
  localparam int LIMIT_W   = 4;
  localparam int BASE_W    = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 8;
  localparam int SHL_W     = BASE_W + 15;

  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 120;

  localparam logic [OP_W-1:0] OP_ACCEPT = 2'd0;
  localparam logic [OP_W-1:0] OP_REPLY  = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

  localparam logic [ACT_W-1:0] ACT_QUERY   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_REJECT  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_FORWARD = 3'd2;
  localparam logic [ACT_W-1:0] ACT_UNREACH = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DONE    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_TIMEOUT = 1'd1;

  localparam logic [LIMIT_W-1:0] RESET_RETRY_LIMIT  = 4'd4;
  localparam logic [BASE_W-1:0]  RESET_BASE_TIMEOUT = 8'd10;

  localparam logic [TRIES_W-1:0] TRIES_MAX = 4'hF;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [IP_W-1:0]     ip;
    logic [MASK_W-1:0]   mask;
    logic [TRIES_W-1:0]  tries;
    logic [TIME_W-1:0]   time_left;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [ACT_W-1:0]    action;
    logic [HANDLE_W-1:0] handle;
    logic [IP_W-1:0]     ip;
    logic [MASK_W-1:0]   mask;
    logic [MAC_W-1:0]    mac;
    logic                last;
  } result_t;

endpackage

/* rtl/core/arp_pending_retry_queue.sv */
// top level of the arp pending retry queue
//
// packets waiting for address resolution sit in NUM_SLOTS slots kept in one
// ram; busy bits live in flip-flops. input beats on the s_axis channel carry
// an operation in tuser: accept, resolution reply or time tick. every input
// beat yields its event beats on m_axis (query, reject, forward, unreachable)
// followed by one done beat with tlast high.
// an accept passes through ST_ACC (query or reject beat) and then ST_DONE.
// a reply or tick reads the slot ram one entry per cycle while m_axis is not
// stalled, through its single read port, and writes the updated entry back
// behind it; a new input beat is taken once the done beat is in the output
// register.
// a stalled m_axis holds its beat in the output register and the scan waits
// on the slot that needs to emit; s_axis_tready stays low meanwhile.
// reset clears busy bits, the started flag and the output; the registers
// return to retry_limit 4 and base_timeout_ms 10. slot contents need no reset.
// cfg_we writes cfg_data to register cfg_index (0 retry_limit, 1
// base_timeout_ms); the new value takes effect in the next cycle.
module arp_pending_retry_queue #(
  parameter int NUM_SLOTS = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [apq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [apq_pkg::CFG_W-1:0]        cfg_data,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // packet_handle, dst_ip, port_mask, reply_mac, elapsed_ms
  input  logic [apq_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // operation
  input  logic [apq_pkg::OP_W-1:0]         s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // out_handle, out_ip, out_mask, out_mac
  output logic [apq_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // action
  output logic [apq_pkg::ACT_W-1:0]        m_axis_tuser,
  output logic                             m_axis_tlast
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  apq_pkg::entry_t       ram_wdata;
  logic                  ram_re;
  logic [IDX_W-1:0]      ram_raddr;
  logic [apq_pkg::ENTRY_W-1:0] ram_rbits;
  logic                  res_valid;
  apq_pkg::result_t      res;
  logic                  res_ready;

  apq_ctrl #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_op      (s_axis_tuser),
    .in_handle  (s_axis_tdata[7:0]),
    .in_ip      (s_axis_tdata[39:8]),
    .in_mask    (s_axis_tdata[71:40]),
    .in_mac     (s_axis_tdata[119:72]),
    .in_elapsed (s_axis_tdata[135:120]),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (apq_pkg::entry_t'(ram_rbits)),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (res_ready)
  );

  apq_ram #(
    .WIDTH(apq_pkg::ENTRY_W),
    .DEPTH(NUM_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rbits)
  );

  apq_out_reg u_out_reg (
    .clk           (clk),
    .rst           (rst),
    .res_valid     (res_valid),
    .res           (res),
    .res_ready     (res_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

/* rtl/core/apq_ram.sv */
// generic single-port-write ram with registered read
module apq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/apq_out_reg.sv */
// output register holding one result beat
module apq_out_reg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           res_valid,
  input  apq_pkg::result_t               res,
  output logic                           res_ready,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [apq_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // handle, ip, mask, mac
  output logic [apq_pkg::ACT_W-1:0]      m_axis_tuser,  // action
  output logic                           m_axis_tlast
);

  apq_pkg::result_t hold;

  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      hold <= res;
    end
  end

  assign m_axis_tdata = {hold.mac, hold.mask, hold.ip, hold.handle};
  assign m_axis_tuser = hold.action;
  assign m_axis_tlast = hold.last;

endmodule

/* rtl/core/apq_ctrl.sv */
// sequencer: slot allocation, reply match and tick scan over the slot ram
module apq_ctrl #(
  parameter int NUM_SLOTS = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [apq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [apq_pkg::CFG_W-1:0]        cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [apq_pkg::OP_W-1:0]         in_op,
  input  logic [apq_pkg::HANDLE_W-1:0]     in_handle,
  input  logic [apq_pkg::IP_W-1:0]         in_ip,
  input  logic [apq_pkg::MASK_W-1:0]       in_mask,
  input  logic [apq_pkg::MAC_W-1:0]        in_mac,
  input  logic [apq_pkg::ELAPSED_W-1:0]    in_elapsed,
  output logic                             ram_we,
  output logic [((NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1)-1:0] ram_waddr,
  output apq_pkg::entry_t                  ram_wdata,
  output logic                             ram_re,
  output logic [((NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1)-1:0] ram_raddr,
  input  apq_pkg::entry_t                  ram_rdata,
  output logic                             res_valid,
  output apq_pkg::result_t                 res,
  input  logic                             res_ready
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NUM_SLOTS);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ACC  = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state;

  logic [NUM_SLOTS-1:0]            busy;
  logic                            started;
  logic [apq_pkg::LIMIT_W-1:0]     retry_limit;
  logic [apq_pkg::BASE_W-1:0]      base_timeout;

  logic [apq_pkg::OP_W-1:0]        op_r;
  logic [apq_pkg::HANDLE_W-1:0]    handle_r;
  logic [apq_pkg::IP_W-1:0]        ip_r;
  logic [apq_pkg::MASK_W-1:0]      mask_r;
  logic [apq_pkg::MAC_W-1:0]       mac_r;
  logic [apq_pkg::ELAPSED_W-1:0]   elapsed_r;

  logic [CNT_W-1:0]                rd_cnt;
  logic                            ev_valid;
  logic [IDX_W-1:0]                ev_idx;

  logic                            has_free;
  logic [IDX_W-1:0]                free_idx;
  logic                            ev_busy;
  logic                            need_out;
  logic                            ev_clear;
  logic                            ev_write;
  apq_pkg::entry_t                 ev_entry;
  apq_pkg::result_t                ev_res;
  logic                            stall;
  logic                            issue;
  logic [apq_pkg::SHL_W-1:0]       shl;
  logic [apq_pkg::TIME_W-1:0]      backoff;

  assign in_ready = (state == ST_IDLE);

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!busy[i]) begin
        free_idx = IDX_W'(i);
      end
    end
    has_free = ~&busy;
  end

  assign shl = apq_pkg::SHL_W'(base_timeout) << ram_rdata.tries;
  assign backoff = (shl[apq_pkg::SHL_W-1:apq_pkg::TIME_W] != '0)
                   ? {apq_pkg::TIME_W{1'b1}} : shl[apq_pkg::TIME_W-1:0];

  // evaluate the slot whose entry just came out of the ram
  always_comb begin
    ev_busy  = busy[ev_idx];
    need_out = 1'b0;
    ev_clear = 1'b0;
    ev_write = 1'b0;
    ev_entry = ram_rdata;
    ev_res   = '0;
    ev_res.handle = ram_rdata.handle;
    ev_res.ip     = ram_rdata.ip;
    if (state == ST_SCAN && ev_valid && ev_busy) begin
      if (op_r == apq_pkg::OP_REPLY) begin
        if (ram_rdata.ip == ip_r) begin
          need_out      = 1'b1;
          ev_clear      = 1'b1;
          ev_res.action = apq_pkg::ACT_FORWARD;
          ev_res.mask   = ram_rdata.mask;
          ev_res.mac    = mac_r;
        end
      end else if (ram_rdata.time_left < elapsed_r) begin
        need_out = 1'b1;
        if (ram_rdata.tries <= retry_limit && ram_rdata.tries != apq_pkg::TRIES_MAX) begin
          ev_write           = 1'b1;
          ev_entry.time_left = backoff;
          ev_entry.tries     = ram_rdata.tries + 1'b1;
          ev_res.action      = apq_pkg::ACT_QUERY;
        end else begin
          ev_clear      = 1'b1;
          ev_res.action = apq_pkg::ACT_UNREACH;
        end
      end else begin
        ev_write           = 1'b1;
        ev_entry.time_left = ram_rdata.time_left - elapsed_r;
      end
    end
  end

  assign stall = need_out && !res_ready;
  assign issue = (state == ST_SCAN) && (rd_cnt < LAST_CNT) && !stall;

  assign ram_re    = issue;
  assign ram_raddr = rd_cnt[IDX_W-1:0];

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ev_idx;
    ram_wdata = ev_entry;
    res_valid = 1'b0;
    res       = ev_res;
    unique case (state)
      ST_IDLE: begin
      end
      ST_ACC: begin
        res_valid        = 1'b1;
        res              = '0;
        res.handle       = handle_r;
        res.ip           = ip_r;
        res.action       = has_free ? apq_pkg::ACT_QUERY : apq_pkg::ACT_REJECT;
        ram_we           = res_ready && has_free;
        ram_waddr        = free_idx;
        ram_wdata.handle    = handle_r;
        ram_wdata.ip        = ip_r;
        ram_wdata.mask      = mask_r;
        ram_wdata.tries     = apq_pkg::TRIES_W'(1);
        ram_wdata.time_left = apq_pkg::TIME_W'(base_timeout);
      end
      ST_SCAN: begin
        res_valid = need_out;
        ram_we    = ev_write && !stall;
      end
      ST_DONE: begin
        res_valid     = 1'b1;
        res           = '0;
        res.action    = apq_pkg::ACT_DONE;
        res.last      = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      busy         <= '0;
      started      <= 1'b0;
      retry_limit  <= apq_pkg::RESET_RETRY_LIMIT;
      base_timeout <= apq_pkg::RESET_BASE_TIMEOUT;
      ev_valid     <= 1'b0;
      rd_cnt       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          apq_pkg::REG_RETRY_LIMIT:  retry_limit  <= cfg_data[apq_pkg::LIMIT_W-1:0];
          apq_pkg::REG_BASE_TIMEOUT: base_timeout <= cfg_data;
          default: begin
          end
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            rd_cnt   <= '0;
            ev_valid <= 1'b0;
            if (in_op == apq_pkg::OP_ACCEPT) begin
              started <= 1'b1;
              state   <= ST_ACC;
            end else if (in_op == apq_pkg::OP_REPLY
                         || (in_op == apq_pkg::OP_TICK && started)) begin
              state <= ST_SCAN;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_ACC: begin
          if (res_ready) begin
            if (has_free) begin
              busy[free_idx] <= 1'b1;
            end
            state <= ST_DONE;
          end
        end
        ST_SCAN: begin
          if (!stall) begin
            if (ev_clear) begin
              busy[ev_idx] <= 1'b0;
            end
            ev_valid <= issue;
            if (issue) begin
              rd_cnt <= rd_cnt + 1'b1;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      op_r      <= in_op;
      handle_r  <= in_handle;
      ip_r      <= in_ip;
      mask_r    <= in_mask;
      mac_r     <= in_mac;
      elapsed_r <= in_elapsed;
    end
    if (issue) begin
      ev_idx <= rd_cnt[IDX_W-1:0];
    end
  end

endmodule

/* rtl/core/apq_checker.sv */
// port-level checks of the arp pending retry queue, bound to the top level
module apq_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [apq_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [apq_pkg::ACT_W-1:0]      m_axis_tuser,
  input logic                           m_axis_tlast
);

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

  // closing beat is a done beat with empty data
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |->
      m_axis_tuser == apq_pkg::ACT_DONE && m_axis_tdata == '0)
    else $error("closing beat is not a clean done beat");

  // done only closes an input
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser != apq_pkg::ACT_DONE)
    else $error("done beat without tlast");

  // one input in work at a time
  a_one_input: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while previous one is in work");

  // output idle right after reset
  a_no_early_out: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind arp_pending_retry_queue apq_checker u_apq_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
